// File: rtl/kts_pkg.sv
// Package for the keyframe track sampler: store geometry, field widths and helpers.
// Used by the core and the divider in rtl; depends on nothing.
package kts_pkg;
   localparam int Keys = 256;
   localparam int KeyIdxW = $clog2(Keys);
   localparam int CountW = 9;
   localparam int TimeW = 24;
   localparam int ValW = 32;
   localparam int SegW = 8;
   localparam int NumW = TimeW + 1;
   localparam int DiffW = ValW + 1;
   localparam int ProdW = NumW + DiffW;
   localparam int QuoW = ProdW;
   localparam int DivCntW = $clog2(QuoW + 1);

   localparam logic OpLoad = 1'b0;
   localparam logic OpSample = 1'b1;

   typedef struct packed {
      logic signed [ValW-1:0] x;
      logic signed [ValW-1:0] y;
      logic signed [ValW-1:0] z;
   } vec_type;

   function automatic logic signed [ValW-1:0] sat32(input logic signed [QuoW:0] v);
      logic signed [QuoW:0] hi;
      logic signed [QuoW:0] lo;
      hi = (QuoW+1)'(32'sh7fffffff);
      lo = -(QuoW+1)'(33'sh080000000);
      if (v > hi) begin
         return ValW'(hi);
      end else if (v < lo) begin
         return ValW'(lo);
      end
      return ValW'(v);
   endfunction
endpackage

// File: rtl/keyframe_track_sampler_core.sv
// Top level of the keyframe track sampler: key store, segment search and interpolation.
// Depends on kts_pkg and kts_divider.
//
// channel  direction  ports
// req      in         req_valid/req_ready, op, key fields, sample_time
// rsp      out        rsp_valid/rsp_ready, out_x/y/z, segment
// csr      in         csr_valid/csr_ready, csr_key_count
//
// A load is written in its accepting cycle and leaves the block ready for the next item.
// A sample checks the keys in turn from the cached segment (states RD_C and CHK per key),
// reads both bracket keys, then runs the serial divider once per component. With one key
// in use a sample returns key 0 without a search or a division.
// Reset is synchronous; the key store is not cleared. The result waits in an output
// register, and no new item is accepted until it is taken.
module keyframe_track_sampler_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [7:0]                          req_key_index,
   input  logic [kts_pkg::TimeW-1:0]           req_key_time,
   input  logic signed [kts_pkg::ValW-1:0]     req_value_x,
   input  logic signed [kts_pkg::ValW-1:0]     req_value_y,
   input  logic signed [kts_pkg::ValW-1:0]     req_value_z,
   input  logic [kts_pkg::TimeW-1:0]           req_sample_time,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [kts_pkg::ValW-1:0]     rsp_out_x,
   output logic signed [kts_pkg::ValW-1:0]     rsp_out_y,
   output logic signed [kts_pkg::ValW-1:0]     rsp_out_z,
   output logic [kts_pkg::SegW-1:0]            rsp_segment,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kts_pkg::CountW-1:0]          csr_key_count
);
   typedef enum logic [3:0] {
      IDLE, RD_A, WT_A, RD_C, CHK, RD_S, WT_S, RD_N, WT_N, DSTART, DWAIT, DONE
   } state_type;

   logic [kts_pkg::TimeW-1:0] time_mem [kts_pkg::Keys];
   kts_pkg::vec_type val_mem [kts_pkg::Keys];

   state_type state_ff, state_in;
   logic [kts_pkg::CountW-1:0] count_ff;
   logic [kts_pkg::KeyIdxW-1:0] cache_ff, cache_in;
   logic [kts_pkg::CountW-1:0] idx_ff, idx_in;
   logic [kts_pkg::KeyIdxW-1:0] seg_ff, seg_in;
   logic [kts_pkg::TimeW-1:0] t_ff, t_in;
   logic [kts_pkg::TimeW-1:0] tprev_ff, tprev_in;
   logic [kts_pkg::KeyIdxW-1:0] raddr;
   logic [kts_pkg::TimeW-1:0] rtime_ff;
   kts_pkg::vec_type rval_ff;
   kts_pkg::vec_type v0_ff, v0_in, v1_ff, v1_in;
   logic [kts_pkg::TimeW-1:0] ts_ff, ts_in;
   logic [1:0] comp_ff, comp_in;
   kts_pkg::vec_type res_ff, res_in;
   logic [kts_pkg::SegW-1:0] rseg_ff, rseg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [kts_pkg::CountW-1:0] n_eff;
   logic mem_we;
   logic dstart, ddone;
   logic signed [kts_pkg::NumW-1:0] num, den;
   logic signed [kts_pkg::DiffW-1:0] diff;
   logic signed [kts_pkg::ValW-1:0] v0c, v1c;
   logic signed [kts_pkg::QuoW-1:0] quot;
   logic signed [kts_pkg::ValW-1:0] outc;
   logic req_fire;

   assign n_eff = (count_ff == '0) ? kts_pkg::CountW'(1)
                : (count_ff > kts_pkg::CountW'(kts_pkg::Keys)) ? kts_pkg::CountW'(kts_pkg::Keys)
                : count_ff;
   assign req_ready = (state_ff == IDLE) && !rsp_valid_ff;
   assign req_fire = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign mem_we = req_fire && (req_op == kts_pkg::OpLoad);
   assign raddr = (state_ff == IDLE) ? '0 : idx_ff[kts_pkg::KeyIdxW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         time_mem[req_key_index[kts_pkg::KeyIdxW-1:0]] <= req_key_time;
         val_mem[req_key_index[kts_pkg::KeyIdxW-1:0]] <= '{x: req_value_x, y: req_value_y,
                                                            z: req_value_z};
      end
      rtime_ff <= time_mem[raddr];
      rval_ff <= val_mem[raddr];
   end

   always_comb begin
      unique case (comp_ff)
         2'd0: begin
            v0c = v0_ff.x;
            v1c = v1_ff.x;
         end
         2'd1: begin
            v0c = v0_ff.y;
            v1c = v1_ff.y;
         end
         default: begin
            v0c = v0_ff.z;
            v1c = v1_ff.z;
         end
      endcase
   end

   assign num = kts_pkg::NumW'(t_ff) - kts_pkg::NumW'(ts_ff);
   assign den = kts_pkg::NumW'(rtime_ff) - kts_pkg::NumW'(ts_ff);
   assign diff = kts_pkg::DiffW'(v1c) - kts_pkg::DiffW'(v0c);
   assign dstart = (state_ff == DSTART);
   assign outc = (den == '0) ? v0c
               : kts_pkg::sat32((kts_pkg::QuoW+1)'(v0c) + (kts_pkg::QuoW+1)'(quot));

   kts_divider u_div (
      .clock(clock), .reset(reset), .start(dstart), .num(num), .diff(diff), .den(den),
      .done(ddone), .quot(quot)
   );

   always_comb begin
      state_in = state_ff;
      cache_in = cache_ff;
      idx_in = idx_ff;
      seg_in = seg_ff;
      t_in = t_ff;
      tprev_in = tprev_ff;
      v0_in = v0_ff;
      v1_in = v1_ff;
      ts_in = ts_ff;
      comp_in = comp_ff;
      res_in = res_ff;
      rseg_in = rseg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         IDLE: begin
            if (req_fire && req_op == kts_pkg::OpSample) begin
               t_in = req_sample_time;
               if (n_eff == kts_pkg::CountW'(1)) begin
                  idx_in = '0;
                  state_in = RD_A;
               end else if (kts_pkg::CountW'(cache_ff) + 1'b1 < n_eff) begin
                  idx_in = kts_pkg::CountW'(cache_ff);
                  seg_in = '0;
                  state_in = RD_S;
               end else begin
                  idx_in = '0;
                  seg_in = '0;
                  cache_in = '0;
                  state_in = RD_N;
               end
            end
         end
         RD_A: state_in = WT_A;
         WT_A: begin
            res_in = rval_ff;
            rseg_in = '0;
            rsp_valid_in = 1'b1;
            state_in = IDLE;
         end
         RD_S: state_in = WT_S;
         WT_S: begin
            tprev_in = rtime_ff;
            idx_in = idx_ff + 1'b1;
            state_in = RD_C;
         end
         RD_C: state_in = CHK;
         CHK: begin
            if (t_ff >= tprev_ff && t_ff < rtime_ff) begin
               seg_in = idx_ff[kts_pkg::KeyIdxW-1:0] - 1'b1;
               cache_in = idx_ff[kts_pkg::KeyIdxW-1:0] - 1'b1;
               idx_in = idx_ff - 1'b1;
               state_in = RD_N;
            end else if (idx_ff + 1'b1 < n_eff) begin
               tprev_in = rtime_ff;
               idx_in = idx_ff + 1'b1;
               state_in = RD_C;
            end else begin
               seg_in = '0;
               cache_in = '0;
               idx_in = '0;
               state_in = RD_N;
            end
         end
         DSTART: state_in = DWAIT;
         DWAIT: begin
            if (ddone) begin
               unique case (comp_ff)
                  2'd0: res_in.x = outc;
                  2'd1: res_in.y = outc;
                  default: res_in.z = outc;
               endcase
               if (comp_ff == 2'd2) begin
                  state_in = DONE;
               end else begin
                  comp_in = comp_ff + 1'b1;
                  state_in = DSTART;
               end
            end
         end
         DONE: begin
            rseg_in = seg_ff;
            rsp_valid_in = 1'b1;
            state_in = IDLE;
         end
         RD_N: state_in = WT_N;
         WT_N: begin
            // Sequence: fetch lower key (idx=seg), then upper key (idx=seg+1).
            if (idx_ff == kts_pkg::CountW'(seg_ff)) begin
               v0_in = rval_ff;
               ts_in = rtime_ff;
               idx_in = kts_pkg::CountW'(seg_ff) + 1'b1;
               state_in = RD_N;
            end else begin
               v1_in = rval_ff;
               comp_in = '0;
               state_in = DSTART;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cache_ff <= '0;
         count_ff <= kts_pkg::CountW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cache_ff <= cache_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_key_count;
         end
      end
      idx_ff <= idx_in;
      seg_ff <= seg_in;
      t_ff <= t_in;
      tprev_ff <= tprev_in;
      v0_ff <= v0_in;
      v1_ff <= v1_in;
      ts_ff <= ts_in;
      comp_ff <= comp_in;
      res_ff <= res_in;
      rseg_ff <= rseg_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = res_ff.x;
   assign rsp_out_y = res_ff.y;
   assign rsp_out_z = res_ff.z;
   assign rsp_segment = rseg_ff;
endmodule

// File: rtl/kts_divider.sv
// Bit-serial signed divider: quotient of num * diff by den, truncated toward zero.
// Depends on kts_pkg. A shift-add multiply precedes a restoring division, one bit per cycle.
module kts_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [kts_pkg::NumW-1:0]     num,
   input  logic signed [kts_pkg::DiffW-1:0]    diff,
   input  logic signed [kts_pkg::NumW-1:0]     den,
   output logic                                done,
   output logic signed [kts_pkg::QuoW-1:0]     quot
);
   typedef enum logic [1:0] {IDLE, MUL, DIV, FIN} state_type;
   state_type state_ff, state_in;
   logic [kts_pkg::DivCntW-1:0] cnt_ff, cnt_in;
   logic [kts_pkg::ProdW-1:0] prod_ff, prod_in;
   logic [kts_pkg::DiffW-1:0] mcand_ff, mcand_in;
   logic [kts_pkg::NumW-1:0] mplier_ff, mplier_in;
   logic [kts_pkg::NumW-1:0] dmag_ff, dmag_in;
   logic [kts_pkg::NumW:0] rem_ff, rem_in;
   logic neg_ff, neg_in;
   logic done_ff, done_in;
   logic [kts_pkg::NumW:0] trial;

   always_comb begin
      trial = {rem_ff[kts_pkg::NumW-1:0], prod_ff[kts_pkg::ProdW-1]} - {1'b0, dmag_ff};
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      prod_in = prod_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      dmag_in = dmag_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               mcand_in = diff[kts_pkg::DiffW-1] ? kts_pkg::DiffW'(-diff) : kts_pkg::DiffW'(diff);
               mplier_in = num[kts_pkg::NumW-1] ? kts_pkg::NumW'(-num) : kts_pkg::NumW'(num);
               dmag_in = den[kts_pkg::NumW-1] ? kts_pkg::NumW'(-den) : kts_pkg::NumW'(den);
               neg_in = num[kts_pkg::NumW-1] ^ diff[kts_pkg::DiffW-1] ^ den[kts_pkg::NumW-1];
               prod_in = '0;
               cnt_in = '0;
               state_in = MUL;
            end
         end
         MUL: begin
            prod_in = (prod_ff << 1)
                      + (mplier_ff[kts_pkg::NumW-1] ? kts_pkg::ProdW'(mcand_ff) : '0);
            mplier_in = mplier_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == kts_pkg::DivCntW'(kts_pkg::NumW - 1)) begin
               cnt_in = '0;
               rem_in = '0;
               state_in = DIV;
            end
         end
         DIV: begin
            if (!trial[kts_pkg::NumW]) begin
               rem_in = trial;
               prod_in = {prod_ff[kts_pkg::ProdW-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[kts_pkg::NumW-1:0], prod_ff[kts_pkg::ProdW-1]};
               prod_in = {prod_ff[kts_pkg::ProdW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == kts_pkg::DivCntW'(kts_pkg::ProdW - 1)) begin
               state_in = FIN;
            end
         end
         FIN: begin
            done_in = 1'b1;
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      prod_ff <= prod_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      dmag_ff <= dmag_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? kts_pkg::QuoW'(-prod_ff) : kts_pkg::QuoW'(prod_ff);
endmodule

// File: rtl/kts_checker.sv
// Port-level checker for the keyframe track sampler core, bound to the top level.
// Depends only on the top level's ports.
module kts_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_op,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [7:0] rsp_segment
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_segment))
      else $error("result item dropped or changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item accepted while a result waits");
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_op |=> !rsp_valid)
      else $error("load item produced a result");
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op |=> !req_ready)
      else $error("sample item did not occupy the block");
endmodule

bind keyframe_track_sampler_core kts_checker u_kts_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_op(req_op), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_segment(rsp_segment)
);

// File: tb/sv/tb.sv
// Self-checking testbench for keyframe_track_sampler_core: loads key tracks, samples
// them under random handshake stalls and checks every result against a local predictor.
// Depends on kts_pkg and the RTL of the block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {KIND_REQ, KIND_CFG, KIND_DRAIN} kind_type;

   typedef struct {
      kind_type kind;
      logic op;
      logic [7:0] index;
      logic [kts_pkg::TimeW-1:0] ktime;
      logic [kts_pkg::ValW-1:0] vx, vy, vz;
      logic [kts_pkg::TimeW-1:0] stime;
      logic [kts_pkg::CountW-1:0] count;
   } job_type;

   typedef struct {
      logic [kts_pkg::ValW-1:0] x, y, z;
      logic [kts_pkg::SegW-1:0] seg;
   } sample_type;

   logic clock, reset;
   logic req_valid, req_ready, req_op;
   logic [7:0] req_key_index;
   logic [kts_pkg::TimeW-1:0] req_key_time, req_sample_time;
   logic signed [kts_pkg::ValW-1:0] req_value_x, req_value_y, req_value_z;
   logic rsp_valid, rsp_ready;
   logic signed [kts_pkg::ValW-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [kts_pkg::SegW-1:0] rsp_segment;
   logic csr_valid, csr_ready;
   logic [kts_pkg::CountW-1:0] csr_key_count;

   keyframe_track_sampler_core dut (.*);

   job_type jobs[$];
   sample_type expected_samples[$];
   logic [kts_pkg::TimeW-1:0] track_time[kts_pkg::Keys];
   longint track_val[kts_pkg::Keys][3];
   int unsigned seg_cache, key_total;
   int errors, quiet, stall_cycles, req_gap, rsp_stall, items;
   bit req_took, csr_took, rsp_took, burst;

   initial clock = 0;
   always #1 clock = ~clock;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic sample_type predict_sample(logic [kts_pkg::TimeW-1:0] st);
      sample_type r;
      int unsigned n, seg, i;
      longint t, num, den, v0;
      bit found;
      n = key_total == 0 ? 1 : (key_total > kts_pkg::Keys ? kts_pkg::Keys : key_total);
      t = st;
      seg = 0;
      found = 0;
      if (n == 1) begin
         r.x = kts_pkg::ValW'(track_val[0][0]);
         r.y = kts_pkg::ValW'(track_val[0][1]);
         r.z = kts_pkg::ValW'(track_val[0][2]);
         r.seg = 0;
         return r;
      end
      for (i = seg_cache; i + 1 < n; i++) begin
         if (t >= track_time[i] && t < track_time[i+1]) begin
            seg = i;
            found = 1;
            break;
         end
      end
      seg_cache = found ? seg : 0;
      num = t - longint'(track_time[seg]);
      den = longint'(track_time[seg+1]) - longint'(track_time[seg]);
      for (int c = 0; c < 3; c++) begin
         v0 = track_val[seg][c];
         if (den != 0) v0 = clamp32(v0 + (num * (track_val[seg+1][c] - v0)) / den);
         if (c == 0) r.x = kts_pkg::ValW'(v0);
         else if (c == 1) r.y = kts_pkg::ValW'(v0);
         else r.z = kts_pkg::ValW'(v0);
      end
      r.seg = kts_pkg::SegW'(seg);
      return r;
   endfunction

   task automatic add_load(int idx, logic [kts_pkg::TimeW-1:0] kt,
                           logic [kts_pkg::ValW-1:0] x, y, z);
      job_type j;
      j.kind = KIND_REQ;
      j.op = kts_pkg::OpLoad;
      j.index = 8'(idx);
      j.ktime = kt;
      j.vx = x;
      j.vy = y;
      j.vz = z;
      j.stime = kts_pkg::TimeW'($urandom);
      j.count = 0;
      jobs.insert(jobs.size(), j);
      items++;
   endtask

   task automatic add_sample(logic [kts_pkg::TimeW-1:0] st);
      job_type j;
      j.kind = KIND_REQ;
      j.op = kts_pkg::OpSample;
      j.index = 8'($urandom);
      j.ktime = kts_pkg::TimeW'($urandom);
      j.vx = $urandom;
      j.vy = $urandom;
      j.vz = $urandom;
      j.stime = st;
      j.count = 0;
      jobs.insert(jobs.size(), j);
      items++;
   endtask

   task automatic add_job(kind_type k, logic [kts_pkg::CountW-1:0] cnt);
      job_type j;
      j.kind = k;
      j.op = kts_pkg::OpLoad;
      j.index = 0;
      j.ktime = 0;
      j.vx = 0;
      j.vy = 0;
      j.vz = 0;
      j.stime = 0;
      j.count = cnt;
      jobs.insert(jobs.size(), j);
   endtask

   task automatic add_track(int n, bit sorted, output int unsigned lo, output int unsigned hi);
      int unsigned t;
      t = $urandom_range(0, 1000);
      lo = t;
      for (int i = 0; i < n; i++) begin
         if (!sorted) t = $urandom;
         else if (i > 0) t += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2000);
         add_load(i, t[kts_pkg::TimeW-1:0], $urandom, $urandom, $urandom);
      end
      hi = t;
   endtask

   // Acceptance, prediction and result checking.
   always @(posedge clock) begin
      req_took <= req_valid && req_ready;
      csr_took <= csr_valid && csr_ready;
      rsp_took <= rsp_valid && rsp_ready;
      if (reset) begin
         seg_cache = 0;
         key_total <= 1;
         quiet <= 0;
         stall_cycles <= 0;
      end else begin
         quiet <= (req_valid && req_ready) ? 0 : quiet + 1;
         if ((req_valid && req_ready) || (csr_valid && csr_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (csr_valid && csr_ready) key_total <= csr_key_count;
         if (req_valid && req_ready) begin
            if (req_op == kts_pkg::OpLoad) begin
               track_time[req_key_index] = req_key_time;
               track_val[req_key_index][0] = req_value_x;
               track_val[req_key_index][1] = req_value_y;
               track_val[req_key_index][2] = req_value_z;
            end else begin
               expected_samples.insert(expected_samples.size(),
                                       predict_sample(req_sample_time));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               errors++;
               if (errors <= 10) $display("Unexpected result item: seg %0d", rsp_segment);
            end else begin
               sample_type e;
               e = expected_samples.pop_front();
               if (e.x !== rsp_out_x || e.y !== rsp_out_y || e.z !== rsp_out_z
                   || e.seg !== rsp_segment) begin
                  errors++;
                  if (errors <= 10)
                     $display("Mismatch: expected %h %h %h seg %0d, got %h %h %h seg %0d",
                              e.x, e.y, e.z, e.seg, rsp_out_x, rsp_out_y, rsp_out_z,
                              rsp_segment);
               end
            end
         end
         if (stall_cycles > 6000) begin
            $display("Timeout waiting for handshake.");
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Request and register driver.
   always @(negedge clock) begin
      logic nv, cv;
      nv = req_valid;
      cv = csr_valid;
      if (req_valid && req_took) nv = 0;
      if (csr_valid && csr_took) cv = 0;
      if (!reset && !nv && !cv) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (jobs.size() > 0) begin
            case (jobs[0].kind)
               KIND_REQ: begin
                  req_op <= jobs[0].op;
                  req_key_index <= jobs[0].index;
                  req_key_time <= jobs[0].ktime;
                  req_value_x <= jobs[0].vx;
                  req_value_y <= jobs[0].vy;
                  req_value_z <= jobs[0].vz;
                  req_sample_time <= jobs[0].stime;
                  nv = 1;
                  void'(jobs.pop_front());
                  if ($urandom_range(0, 30) == 0) burst = ~burst;
                  req_gap = burst ? 0 : $urandom_range(0, 13);
               end
               KIND_CFG: begin
                  if (expected_samples.size() == 0 && quiet >= 16) begin
                     csr_key_count <= jobs[0].count;
                     cv = 1;
                     void'(jobs.pop_front());
                  end
               end
               default: begin
                  if (expected_samples.size() == 0) void'(jobs.pop_front());
               end
            endcase
         end
      end
      req_valid <= nv;
      csr_valid <= cv;
   end

   // Result receiver with random stalls.
   always @(negedge clock) begin
      if (rsp_took) rsp_stall = burst ? 0 : $urandom_range(0, 13);
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   initial begin
      int unsigned lo, hi, n, cnt;
      logic [kts_pkg::CountW-1:0] counts[8];
      counts = '{0, 1, 2, 3, 256, 257, 511, 300};
      reset = 1;
      req_valid = 0;
      req_op = 0;
      req_key_index = 0;
      req_key_time = 0;
      req_value_x = 0;
      req_value_y = 0;
      req_value_z = 0;
      req_sample_time = 0;
      csr_valid = 0;
      csr_key_count = 0;
      rsp_ready = 0;
      rsp_stall = 0;
      req_gap = 0;
      burst = 0;

      add_job(KIND_CFG, 1);
      add_load(0, 0, 32'h7fffffff, 32'h80000000, 0);
      add_sample(0);
      add_sample(24'hffffff);
      add_job(KIND_CFG, 0);
      add_sample(24'h123456);
      add_load(0, 100, 32'h80000000, 32'h7fffffff, 0);
      add_load(1, 200, 32'h7fffffff, 32'h80000000, 10);
      add_load(2, 200, 0, 0, -10);
      add_load(3, 24'hffffff, 32'hffffffff, 1, 32'h40000000);
      add_load(255, 24'haaaaaa, 32'h55555555, 32'haaaaaaaa, 0);
      add_job(KIND_CFG, 4);
      add_sample(150);
      add_sample(24'hfffffe);
      add_sample(200);
      add_sample(0);
      add_sample(24'hffffff);
      add_sample(300);
      add_job(KIND_CFG, 2);
      add_sample(150);
      add_sample(24'h800000);

      add_track(kts_pkg::Keys, 1, lo, hi);
      add_job(KIND_CFG, 256);
      for (int s = 0; s < 40; s++)
         add_sample(kts_pkg::TimeW'($urandom_range(lo, hi + 500)));
      while (items < 720) begin
         cnt = ($urandom_range(0, 2) == 0) ? counts[$urandom_range(0, 7)]
                                           : $urandom_range(2, 16);
         n = cnt == 0 ? 1 : (cnt > kts_pkg::Keys ? kts_pkg::Keys : cnt);
         if (n <= 16) add_track(n, $urandom_range(0, 4) != 0, lo, hi);
         else begin
            lo = 0;
            hi = 600000;
         end
         add_job(KIND_CFG, kts_pkg::CountW'(cnt));
         for (int s = $urandom_range(15, 35); s > 0; s--) begin
            if ($urandom_range(0, 9) == 0)
               add_load($urandom, kts_pkg::TimeW'($urandom), $urandom, $urandom, $urandom);
            else if ($urandom_range(0, 9) == 0) add_sample(kts_pkg::TimeW'($urandom));
            else add_sample(kts_pkg::TimeW'($urandom_range(lo, hi + 500)));
         end
         if (items > 400 && items < 460) add_job(KIND_DRAIN, 0);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;
      wait (jobs.size() == 0 && !req_valid && !csr_valid && expected_samples.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0 && expected_samples.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
